// ===== hw/rtl/sbl_pkg.sv =====
package sbl_pkg;

  // Default depth of the edge table, in bins.
  localparam int MAX_BINS_DEF = 256;

  // Widths fixed by the item format.
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 9;
  localparam int BIN_W    = 8;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FLAGGED = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLAMPED = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_INSIDE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd2;

endpackage

// ===== hw/rtl/sorted_bin_locator_unit.sv =====
// A write or a trivial request goes from acceptance to the hold state and then to the
// output register; a locate makes up to 3 end reads plus ceil(log2(bin_count - 1))
// bisection reads of the edge table, evaluating each as it returns, before the hold state.
// A new request is taken only in the idle state, once the previous result has left the
// hold state, where an output stall keeps it; all edge reads share the single read port.
// Reset: synchronous; the stored bin count returns to 1, the edge table keeps its contents.
module sorted_bin_locator_unit #(
  parameter int MAX_BINS = sbl_pkg::MAX_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbl_pkg::COUNT_W-1:0]         bin_count,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sbl_pkg::REQ_W-1:0]           req_type,
  input  logic [sbl_pkg::INDEX_W-1:0]         edge_index,
  input  logic signed [sbl_pkg::VALUE_W-1:0]  edge_value,
  input  logic signed [sbl_pkg::VALUE_W-1:0]  query_value,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sbl_pkg::BIN_W-1:0]           bin_index,
  output logic [sbl_pkg::STATUS_W-1:0]        status
);

  localparam int IW = $clog2(MAX_BINS + 1);
  localparam int CW = (IW > sbl_pkg::COUNT_W) ? IW : sbl_pkg::COUNT_W;

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  // Which comparison the returning edge read serves.
  localparam logic [1:0] PH_TOP = 2'd0;
  localparam logic [1:0] PH_LOW = 2'd1;
  localparam logic [1:0] PH_ONE = 2'd2;
  localparam logic [1:0] PH_MID = 2'd3;

  logic [1:0]                          state, state_next;
  logic [1:0]                          phase, phase_next;
  logic [sbl_pkg::COUNT_W-1:0]         count_reg;
  logic signed [sbl_pkg::VALUE_W-1:0]  query, query_next;
  logic                                flagged, flagged_next;
  logic [IW-1:0]                       lo, lo_next;
  logic [IW-1:0]                       hi, hi_next;
  logic [IW-1:0]                       mid, mid_next;
  logic [sbl_pkg::BIN_W-1:0]           res_bin, res_bin_next;
  logic [sbl_pkg::STATUS_W-1:0]        res_st, res_st_next;

  logic signed [sbl_pkg::VALUE_W-1:0]  edge_mem [0:MAX_BINS];
  logic signed [sbl_pkg::VALUE_W-1:0]  rd_data;
  logic                                rd_en;
  logic [IW-1:0]                       rd_addr;
  logic                                wr_en;
  logic [IW-1:0]                       wr_addr;

  logic [CW-1:0]                       count_ext;
  logic [IW-1:0]                       n_bins;
  logic                                in_accept;
  logic                                out_free;
  logic [IW-1:0]                       cmp_lo;
  logic [IW-1:0]                       cmp_hi;
  logic [IW:0]                         cmp_sum;
  logic [IW-1:0]                       init_mid;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Bins in use: zero counts as one, anything past the table saturates.
  assign count_ext = CW'(count_reg);
  always_comb begin
    if (count_ext == '0) begin
      n_bins = IW'(1);
    end else if (count_ext > CW'(MAX_BINS)) begin
      n_bins = IW'(MAX_BINS);
    end else begin
      n_bins = IW'(count_ext);
    end
  end

  // Write port decode; indices beyond the table are dropped.
  assign wr_addr = IW'(edge_index);
  assign wr_en   = in_accept && (req_type == sbl_pkg::REQ_WRITE) &&
                   (CW'(edge_index) <= CW'(MAX_BINS));

  // Bisection step: narrow the interval around the midpoint just read.
  always_comb begin
    if (rd_data <= query) begin
      cmp_lo = mid;
      cmp_hi = hi;
    end else begin
      cmp_lo = lo;
      cmp_hi = mid;
    end
    cmp_sum  = {1'b0, cmp_lo} + {1'b0, cmp_hi};
    init_mid = (n_bins - IW'(1)) >> 1;
  end

  // Controller: issues one edge read per cycle while a locate is in progress and evaluates the one that returned.
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    query_next   = query;
    flagged_next = flagged;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    res_bin_next = res_bin;
    res_st_next  = res_st;
    rd_en        = 1'b0;
    rd_addr      = '0;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          res_bin_next = '0;
          res_st_next  = sbl_pkg::ST_INSIDE;
          query_next   = query_value;
          flagged_next = (req_type == sbl_pkg::REQ_FLAGGED);
          if (((req_type == sbl_pkg::REQ_FLAGGED) || (req_type == sbl_pkg::REQ_CLAMPED)) &&
              (n_bins > IW'(1))) begin
            rd_en      = 1'b1;
            rd_addr    = n_bins;
            phase_next = PH_TOP;
            state_next = S_READ;
          end else begin
            state_next = S_HOLD;
          end
        end
      end

      S_READ: begin
        unique case (phase)
          PH_TOP: begin
            if (query >= rd_data) begin
              if (flagged) begin
                res_st_next = sbl_pkg::ST_ABOVE;
              end else begin
                res_bin_next = sbl_pkg::BIN_W'(n_bins - IW'(1));
              end
              state_next = S_HOLD;
            end else if (flagged) begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              phase_next = PH_LOW;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = IW'(1);
              phase_next = PH_ONE;
            end
          end

          PH_LOW: begin
            if (query < rd_data) begin
              res_st_next = sbl_pkg::ST_BELOW;
              state_next  = S_HOLD;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = IW'(1);
              phase_next = PH_ONE;
            end
          end

          PH_ONE: begin
            if (query < rd_data) begin
              state_next = S_HOLD;
            end else begin
              // Value lies between edge 1 and the top edge: start the bisection.
              lo_next = '0;
              hi_next = n_bins - IW'(1);
              if (n_bins > IW'(2)) begin
                mid_next   = init_mid;
                rd_en      = 1'b1;
                rd_addr    = init_mid + IW'(1);
                phase_next = PH_MID;
              end else begin
                res_bin_next = sbl_pkg::BIN_W'(n_bins - IW'(1));
                state_next   = S_HOLD;
              end
            end
          end

          PH_MID: begin
            lo_next = cmp_lo;
            hi_next = cmp_hi;
            if ({1'b0, cmp_hi} > ({1'b0, cmp_lo} + (IW+1)'(1))) begin
              mid_next = cmp_sum[IW:1];
              rd_en    = 1'b1;
              rd_addr  = cmp_sum[IW:1] + IW'(1);
            end else begin
              res_bin_next = sbl_pkg::BIN_W'(cmp_hi);
              state_next   = S_HOLD;
            end
          end

          default: begin
            state_next = S_HOLD;
          end
        endcase
      end

      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Edge table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_mem[wr_addr] <= edge_value;
    end
    if (rd_en) begin
      rd_data <= edge_mem[rd_addr];
    end
  end

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_reg <= sbl_pkg::COUNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        count_reg <= bin_count;
      end
      if ((state == S_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk) begin
    phase   <= phase_next;
    query   <= query_next;
    flagged <= flagged_next;
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    res_bin <= res_bin_next;
    res_st  <= res_st_next;
    if ((state == S_HOLD) && out_free) begin
      bin_index <= res_bin;
      status    <= res_st;
    end
  end

endmodule

// ===== hw/rtl/sbl_checker.sv =====
module sbl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sbl_pkg::BIN_W-1:0]     bin_index,
  input logic [sbl_pkg::STATUS_W-1:0]  status
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bin_index) && $stable(status))
    else $error("result changed while stalled");

  // Only the three defined status codes ever leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == sbl_pkg::ST_INSIDE) || (status == sbl_pkg::ST_BELOW) ||
                  (status == sbl_pkg::ST_ABOVE))
    else $error("undefined status code");

  // An out-of-range flag always comes with bin zero.
  a_flag_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != sbl_pkg::ST_INSIDE) |-> bin_index == '0)
    else $error("flagged result carries a bin");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind sorted_bin_locator_unit sbl_checker u_sbl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .bin_index (bin_index),
  .status    (status)
);
